>>> src/wpm_pkg.sv
// Types and constants shared by the wildcard pattern matcher.
`default_nettype none
package wpm_pkg;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  typedef enum logic [1:0] {
    MODE_PATTERN = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_END     = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  char_value;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

endpackage
`default_nettype wire

>>> src/wildcard_pattern_matcher_core.sv
// Wildcard pattern matcher core: pattern store, reach vector and handshake stages.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------------
//  item     | item_valid, item_ready, item     | mode + char_value, one per transaction
//  result   | result_valid, result_ready, result | matched + pattern_overflow, on end
//
// Cycles: one item per clock sustained while no end-of-text item is held
// back. A transaction lands in the item register when it is accepted; applying
// it updates the state and, for end of text, loads the result register, from
// which the result is offered.
// Reset: synchronous rst empties the pattern, clears overflow and arms the
// reach vector at position zero; no clearing pass, the store needs none.
// Stalls: an end-of-text item sits in the item register while the previous
// result is pending and not taken that cycle, and input waits behind it;
// other modes never wait on the result side.
`default_nettype none
module wildcard_pattern_matcher_core #(
  parameter int MAX_PATTERN = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_ready,
  input  wpm_pkg::item_t     item,
  output logic               result_valid,
  input  wire                result_ready,
  output wpm_pkg::result_t   result
);
  import wpm_pkg::*;

  // pattern_length counts 0..MAX_PATTERN inclusive
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  // levels of the prefix network that closes the reach vector over stars
  localparam int LVL = (LEN_W < 1) ? 1 : LEN_W;

  // ---------------------------------------------------------------------
  // Item register
  // ---------------------------------------------------------------------
  logic  stage_valid;
  item_t item_q;
  logic  is_end;
  logic  advance;

  assign is_end  = (item_q.mode == MODE_END);
  // only end of text produces a result, so only it can be held back
  assign advance = stage_valid && (!is_end || !result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  // ---------------------------------------------------------------------
  // Pattern state
  // ---------------------------------------------------------------------
  logic [7:0]             store [MAX_PATTERN];
  logic [LEN_W-1:0]       pattern_length;
  logic [MAX_PATTERN-1:0] active;        // thermometer: entries below length
  logic [MAX_PATTERN:0]   reach;
  logic                   overflow_flag;

  logic                   has_room;
  logic                   wr_en;
  logic [MAX_PATTERN-1:0] star_cur;
  logic [MAX_PATTERN-1:0] star_next;
  logic [MAX_PATTERN-1:0] active_next;
  logic [MAX_PATTERN-1:0] star_eff;
  logic [LEN_W-1:0]       pattern_length_next;
  logic                   overflow_flag_next;
  logic [MAX_PATTERN:0]   seed;
  logic [MAX_PATTERN:0]   reach_next;

  assign has_room = (pattern_length != LEN_W'(MAX_PATTERN));
  assign wr_en    = advance && (item_q.mode == MODE_PATTERN) && has_room;

  // per-entry decode of the store; entries at or above length are don't-care
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      star_cur[k]  = (store[k] == STAR_BYTE);
      star_next[k] = star_cur[k];
      if ((item_q.mode == MODE_PATTERN) && has_room && (pattern_length == LEN_W'(k))) begin
        star_next[k] = (item_q.char_value == STAR_BYTE);
      end
    end
  end

  // next length / overflow / occupancy, and the vector to be star-closed
  always_comb begin
    pattern_length_next = pattern_length;
    overflow_flag_next  = overflow_flag;
    active_next         = active;
    seed                = '0;
    seed[0]             = 1'b1;
    case (item_q.mode)
      MODE_PATTERN: begin
        if (has_room) begin
          pattern_length_next = pattern_length + LEN_W'(1);
          active_next         = (active << 1) | MAX_PATTERN'(1);
        end else begin
          overflow_flag_next = 1'b1;
        end
      end
      MODE_TEXT: begin
        // one text byte: stars hold their position, literals and '?' step
        seed = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          if (reach[k] && active[k]) begin
            if (star_cur[k]) begin
              seed[k] = 1'b1;
            end else if ((store[k] == QMARK_BYTE) || (store[k] == item_q.char_value)) begin
              seed[k+1] = 1'b1;
            end
          end
        end
      end
      MODE_END: begin
        // rearm only
      end
      MODE_CLEAR: begin
        pattern_length_next = '0;
        overflow_flag_next  = 1'b0;
        active_next         = '0;
      end
      default: begin
      end
    endcase
  end

  assign star_eff = star_next & active_next;

  // Star closure as a carry-style prefix: a reachable star makes the next
  // position reachable, which may be another star, and so on. Generate is
  // the seed, propagate into position j is a star at j-1.
  always_comb begin
    logic [MAX_PATTERN:0] g [LVL+1];
    logic [MAX_PATTERN:0] p [LVL+1];
    g[0] = seed;
    p[0] = {star_eff, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j <= MAX_PATTERN; j++) begin
        if (j >= (1 << l)) begin
          g[l+1][j] = g[l][j] | (p[l][j] & g[l][j-(1<<l)]);
          p[l+1][j] = p[l][j] & p[l][j-(1<<l)];
        end else begin
          g[l+1][j] = g[l][j];
          p[l+1][j] = p[l][j];
        end
      end
    end
    reach_next = g[LVL];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      active         <= '0;
      overflow_flag  <= 1'b0;
      reach          <= {{MAX_PATTERN{1'b0}}, 1'b1};
    end else if (advance) begin
      pattern_length <= pattern_length_next;
      active         <= active_next;
      overflow_flag  <= overflow_flag_next;
      reach          <= reach_next;
    end
  end

  // pattern bytes, written once each at their own slot
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (wr_en && (pattern_length == LEN_W'(k))) begin
        store[k] <= item_q.char_value;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && is_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_end) begin
      result.matched          <= reach[pattern_length];
      result.pattern_overflow <= overflow_flag;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_length <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_active_len: assert property (@(posedge clk) disable iff (rst)
    $countones(active) == int'(pattern_length))
    else $error("occupancy mask out of step with pattern length");

  a_reach_in_range: assert property (@(posedge clk) disable iff (rst)
    (reach & ~{active, 1'b1}) == '0)
    else $error("reach vector set past end of pattern");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (pattern_length == LEN_W'(MAX_PATTERN)))
    else $error("overflow flagged with room in store");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("pending result dropped or changed");

endmodule
`default_nettype wire

>>> bench/wildcard_pattern_matcher_core_tb.sv
// Testbench for the wildcard pattern matcher core: directed and random item streams, checked against a reach-vector predictor.
`timescale 1ns / 100ps
module wildcard_pattern_matcher_core_tb;
  import wpm_pkg::*;

  localparam int MAXP     = 32;
  localparam int HOLD_LEN = 200;   // receiver hold-off, in cycles
  localparam int N_RANDOM = 1250;  // random-phase transactions

  // Predictor and store of expected verdicts. Keeps its own copy of the
  // pattern and of the reach vector, closed over stars.
  class match_tracker;
    logic [7:0]    pat [MAXP];
    int unsigned   pat_len;
    logic [MAXP:0] reach;
    bit            ovf;
    result_t       expected_verdicts [$];
    int            errors;

    function new();
      pat_len = 0;
      ovf     = 1'b0;
      errors  = 0;
      rearm();
    endfunction

    // A reachable star also makes the next position reachable.
    function void close_stars();
      for (int k = 0; k < pat_len; k++) begin
        if (reach[k] && pat[k] == STAR_BYTE) reach[k+1] = 1'b1;
      end
    endfunction

    function void rearm();
      reach    = '0;
      reach[0] = 1'b1;
      close_stars();
    endfunction

    function void step_reach(logic [7:0] c);
      logic [MAXP:0] nxt;
      nxt = '0;
      for (int k = 0; k < pat_len; k++) begin
        if (reach[k]) begin
          if (pat[k] == STAR_BYTE) nxt[k] = 1'b1;
          else if (pat[k] == QMARK_BYTE || pat[k] == c) nxt[k+1] = 1'b1;
        end
      end
      reach = nxt;
      close_stars();
    endfunction

    // Apply one accepted input transaction.
    function void note_item(item_t it);
      result_t verdict;
      case (it.mode)
        MODE_PATTERN: begin
          if (pat_len < MAXP) begin
            pat[pat_len] = it.char_value;
            pat_len++;
          end else begin
            ovf = 1'b1;
          end
          rearm();
        end
        MODE_TEXT: step_reach(it.char_value);
        MODE_END: begin
          verdict.matched          = reach[pat_len];
          verdict.pattern_overflow = ovf;
          expected_verdicts.push_back(verdict);
          rearm();
        end
        default: begin
          pat_len = 0;
          ovf     = 1'b0;
          rearm();
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one accepted result transaction with the oldest expectation.
    task check_result(result_t got);
      result_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result matched=%b overflow=%b",
                                  got.matched, got.pattern_overflow));
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.matched !== want.matched)
        report_mismatch($sformatf("matched got %b want %b", got.matched, want.matched));
      if (got.pattern_overflow !== want.pattern_overflow)
        report_mismatch($sformatf("pattern_overflow got %b want %b",
                                  got.pattern_overflow, want.pattern_overflow));
    endtask
  endclass

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  match_tracker sb;

  // Shared between the sender and the receiver process.
  bit quiet;                 // no idling on either side while set
  int holds_requested = 0;   // sender asks, receiver serves
  int holds_served    = 0;
  int hold_cycles     = 0;
  int sent_items      = 0;

  wildcard_pattern_matcher_core #(
    .MAX_PATTERN (MAXP)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop; far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver: checks every accepted result, stalls at random, and serves
  // long hold-offs that the sender requests. Hold-off length is counted here.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) sb.check_result(result);
      if (holds_served < holds_requested) begin
        result_ready <= 1'b0;
        if (hold_cycles == HOLD_LEN - 1) begin
          hold_cycles = 0;
          holds_served++;
        end else begin
          hold_cycles++;
        end
      end else begin
        result_ready <= quiet || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // One input transaction: optional one-cycle idle gap, then hold valid until taken.
  task automatic send_item(input mode_t m, input logic [7:0] c);
    item_t it;
    it.mode       = m;
    it.char_value = c;
    if (!quiet && $urandom_range(0, 99) < 9) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
    sent_items++;
  endtask

  // Drop valid and wait for every outstanding verdict.
  task automatic wait_for_verdicts();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_verdicts.size() != 0);
  endtask

  // Small alphabet most of the time so that literals actually line up.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return STAR_BYTE;
    if (r < 40) return QMARK_BYTE;
    return pick_byte();
  endfunction

  // One well-formed sequence: optional clear, pattern bytes, text, end.
  // Text is mostly built to match the pattern held right now (truncated
  // pattern included), sometimes mutated, sometimes plain random.
  task automatic run_sequence();
    int         plen;
    int         roll;
    int         spot;
    logic [7:0] txt [$];
    if ($urandom_range(0, 9) < 7) send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
    // Mostly short patterns; now and then one that runs past the store.
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    repeat (plen) send_item(MODE_PATTERN, pattern_byte());
    for (int k = 0; k < sb.pat_len; k++) begin
      if (sb.pat[k] == STAR_BYTE) begin
        repeat ($urandom_range(0, 3)) txt.push_back(pick_byte());
      end else if (sb.pat[k] == QMARK_BYTE) begin
        txt.push_back(($urandom_range(0, 1) == 0) ? pick_byte() : 8'($urandom_range(0, 255)));
      end else begin
        txt.push_back(sb.pat[k]);
      end
    end
    roll = $urandom_range(0, 99);
    if (roll >= 80) begin
      txt.delete();
      repeat ($urandom_range(0, 8)) txt.push_back(pick_byte());
    end else if (roll >= 60 && txt.size() > 0) begin
      spot = $urandom_range(0, txt.size() - 1);
      txt[spot] = pick_byte();
    end
    foreach (txt[i]) send_item(MODE_TEXT, txt[i]);
    send_item(MODE_END, 8'($urandom_range(0, 255)));
  endtask

  // Noise: any mode, any byte, including pattern edits in mid-text.
  task automatic run_noise();
    repeat ($urandom_range(1, 6))
      send_item(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int  base;
    bit  hold_done;
    bit  pause_done;
    sb         = new();
    hold_done  = 1'b0;
    pause_done = 1'b0;
    quiet      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // empty text against empty pattern: match
    send_item(MODE_END, 8'h00);
    // non-empty text against empty pattern: no match
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'hFF);
    // pattern of a single star, empty text: match
    send_item(MODE_PATTERN, STAR_BYTE);
    send_item(MODE_END, 8'h00);
    // byte zero is a plain literal in pattern and text: "*\0" vs FF 00
    send_item(MODE_PATTERN, 8'h00);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'h00);
    // pattern edited mid-text discards the text seen so far: "*\0?"
    send_item(MODE_TEXT, 8'h78);
    send_item(MODE_PATTERN, QMARK_BYTE);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_END, 8'h00);
    // clear, then literal FF followed by a question mark
    send_item(MODE_CLEAR, 8'hFF);
    send_item(MODE_PATTERN, 8'hFF);
    send_item(MODE_PATTERN, QMARK_BYTE);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, 8'h71);
    send_item(MODE_END, 8'h55);
    send_item(MODE_TEXT, 8'hFE);
    send_item(MODE_TEXT, 8'h01);
    send_item(MODE_END, 8'hAA);
    wait_for_verdicts();

    // ---- random ----
    base = sent_items;
    while (sent_items - base < N_RANDOM) begin
      // one long receiver hold-off while the sender keeps pushing, so end
      // items back up and the input stalls
      if (!hold_done && sent_items - base >= 300) begin
        holds_requested++;
        hold_done = 1'b1;
      end
      // a long stretch with no idling on either side
      quiet = (sent_items - base >= 450) && (sent_items - base < 750);
      // one sender pause until every verdict is back
      if (!pause_done && sent_items - base >= 900) begin
        wait_for_verdicts();
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) run_sequence();
      else run_noise();
    end
    quiet = 1'b0;

    wait_for_verdicts();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> wildcard_pattern_matcher_core.f
src/wpm_pkg.sv
src/wildcard_pattern_matcher_core.sv
bench/wildcard_pattern_matcher_core_tb.sv
